// ----- rtl/button_debounce_click_gesture_macros.svh -----
// ----------------------------------------------------------------------------
// Button debounce and click gesture: assertion macros
// Clocked assertion wrappers, compiled out when ASSERT_OFF is defined.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_GESTURE_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_GESTURE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked only while reset is released
`define BDCG_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked at every edge, reset included
`define BDCG_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BDCG_ASSERT(lbl, clk, rstn, prop, msg)
`define BDCG_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/bdcg_pkg.sv -----
// ----------------------------------------------------------------------------
// Button debounce and click gesture: shared package
// Field widths, register indexes, selector codes, reset values and the
// structs passed between the top level and the gesture core.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcg_pkg;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned COUNT_W = 8;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [IDX_W-1:0] CFG_LONG_HOLD  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_CLICK_GAP  = 2'd2;

    // Flag selector codes
    localparam logic [FUNC_W-1:0] FUNC_SHORT  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LONG   = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TRIPLE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

    // Register reset values
    localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd30;
    localparam logic [CFG_W-1:0] LONG_HOLD_RST = 16'd5000;
    localparam logic [CFG_W-1:0] CLICK_GAP_RST = 16'd500;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 8'd255;
    localparam logic [COUNT_W-1:0] TRIPLE_COUNT = 8'd3;
    localparam logic                LEVEL_IDLE   = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] settle_ms;
        logic [CFG_W-1:0] long_hold_ms;
        logic [CFG_W-1:0] click_gap_ms;
    } cfg_t;

    typedef struct packed {
        logic event_res;
        logic short_pending;
        logic long_pending;
        logic triple_pending;
        logic debounced_level;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/bdcg_gesture.sv -----
// ----------------------------------------------------------------------------
// Button debounce and click gesture: gesture core
// Holds the debounce and click state, works out one poll in a single pass
// and commits the new state when the item is stepped.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcg_gesture (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            fire_i,
    input  wire logic                            level_i,
    input  wire logic [bdcg_pkg::TIME_W-1:0]     now_i,
    input  wire logic [bdcg_pkg::FUNC_W-1:0]     func_i,
    input  wire bdcg_pkg::cfg_t                  cfg_i,
    output bdcg_pkg::result_t                    result_o
);
    import bdcg_pkg::*;

    `include "button_debounce_click_gesture_macros.svh"

    logic               last_raw_reg,     last_raw_next;
    logic               stable_level_reg, stable_level_next;
    logic [TIME_W-1:0]  change_time_reg,  change_time_next;
    logic [TIME_W-1:0]  press_time_reg,   press_time_next;
    logic [TIME_W-1:0]  click_time_reg,   click_time_next;
    logic [COUNT_W-1:0] click_count_reg,  click_count_next;
    logic               short_flag_reg,   short_flag_next;
    logic               long_flag_reg,    long_flag_next;
    logic               triple_flag_reg,  triple_flag_next;

    logic [TIME_W-1:0]  db_diff;
    logic [TIME_W-1:0]  hold_diff;
    logic [TIME_W-1:0]  gap_diff;
    logic               raw_changed;
    logic               level_accept;
    logic               release_edge;
    logic               long_release;
    logic               click;
    logic               flush;
    logic [COUNT_W-1:0] count_mid;
    logic               short_mid;
    logic               long_mid;
    logic               triple_mid;
    logic               event_res;

    // A fresh raw change restarts its own timer and blocks the debounce test,
    // so the new level cannot be accepted in the same poll.
    assign raw_changed  = (level_i != last_raw_reg);
    assign db_diff      = now_i - change_time_reg;
    assign level_accept = !raw_changed && (db_diff > TIME_W'(cfg_i.settle_ms))
                          && (level_i != stable_level_reg);
    assign release_edge = level_accept && level_i;

    assign hold_diff    = now_i - press_time_reg;
    assign long_release = release_edge && (hold_diff >= TIME_W'(cfg_i.long_hold_ms));
    assign click        = release_edge && !long_release;

    always_comb begin
        if (long_release) begin
            count_mid = '0;
        end else if (click && (click_count_reg != COUNT_MAX)) begin
            count_mid = click_count_reg + COUNT_W'(1);
        end else begin
            count_mid = click_count_reg;
        end
    end

    // A click in this poll resets the gap timer, so no burst can close now
    assign gap_diff = now_i - click_time_reg;
    assign flush    = (count_mid != '0) && !click && (gap_diff > TIME_W'(cfg_i.click_gap_ms));

    assign short_mid  = short_flag_reg  || (flush && (count_mid <  TRIPLE_COUNT));
    assign triple_mid = triple_flag_reg || (flush && (count_mid >= TRIPLE_COUNT));
    assign long_mid   = long_flag_reg   || long_release;

    always_comb begin
        short_flag_next  = short_mid;
        long_flag_next   = long_mid;
        triple_flag_next = triple_mid;
        unique case (func_i)
            FUNC_SHORT: begin
                event_res       = short_mid;
                short_flag_next = 1'b0;
            end
            FUNC_LONG: begin
                event_res      = long_mid;
                long_flag_next = 1'b0;
            end
            FUNC_TRIPLE: begin
                event_res        = triple_mid;
                triple_flag_next = 1'b0;
            end
            default: begin
                event_res = 1'b0;
            end
        endcase
    end

    assign last_raw_next     = level_i;
    assign change_time_next  = raw_changed ? now_i : change_time_reg;
    assign stable_level_next = level_accept ? level_i : stable_level_reg;
    assign press_time_next   = (level_accept && !level_i) ? now_i : press_time_reg;
    assign click_time_next   = click ? now_i : click_time_reg;
    assign click_count_next  = flush ? '0 : count_mid;

    assign result_o.event_res       = event_res;
    assign result_o.short_pending   = short_flag_next;
    assign result_o.long_pending    = long_flag_next;
    assign result_o.triple_pending  = triple_flag_next;
    assign result_o.debounced_level = stable_level_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_raw_reg     <= LEVEL_IDLE;
            stable_level_reg <= LEVEL_IDLE;
            change_time_reg  <= '0;
            press_time_reg   <= '0;
            click_time_reg   <= '0;
            click_count_reg  <= '0;
            short_flag_reg   <= 1'b0;
            long_flag_reg    <= 1'b0;
            triple_flag_reg  <= 1'b0;
        end else if (fire_i) begin
            last_raw_reg     <= last_raw_next;
            stable_level_reg <= stable_level_next;
            change_time_reg  <= change_time_next;
            press_time_reg   <= press_time_next;
            click_time_reg   <= click_time_next;
            click_count_reg  <= click_count_next;
            short_flag_reg   <= short_flag_next;
            long_flag_reg    <= long_flag_next;
            triple_flag_reg  <= triple_flag_next;
        end
    end

    `BDCG_ASSERT(a_short_consumed, aclk, aresetn, fire_i && (func_i == FUNC_SHORT) |=> !short_flag_reg, "short flag survived its consume")
    `BDCG_ASSERT(a_long_consumed, aclk, aresetn, fire_i && (func_i == FUNC_LONG) |=> !long_flag_reg, "long flag survived its consume")
    `BDCG_ASSERT(a_none_no_event, aclk, aresetn, fire_i && (func_i == FUNC_NONE) |-> !result_o.event_res, "event reported with no flag selected")

endmodule

`default_nettype wire

// ----- rtl/button_debounce_click_gesture.sv -----
// ----------------------------------------------------------------------------
// Button debounce and click gesture: top level
// Polls an active-low button, debounces it and reports click gestures.
// ----------------------------------------------------------------------------
// Usage:
//   Each item on the s_ channel is one poll: raw pin level, millisecond
//   timestamp and a selector naming the gesture flag to consume. Every item
//   gives exactly one result on the m_ channel: the consumed flag, the flags
//   still pending and the debounced level.
//   An accepted item waits in the input register, then passes through the
//   gesture core into the result register, which raises m_valid.
//   Throughput is one item per cycle while the receiver keeps up; the
//   gesture state is updated in the same cycle the item moves into the
//   result register. When the receiver stalls, the result is held and
//   one more item waits in the input register; s_ready drops only once
//   both are full. Registers are written through cfg_wen/cfg_idx/cfg_wdata;
//   an index beyond the list is ignored.
//   Reset clears the gesture state to the released level, no flags pending,
//   and loads the default timings (30, 5000 and 500 ms). No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_gesture (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wen,
    input  wire logic [bdcg_pkg::IDX_W-1:0]   cfg_idx,
    input  wire logic [bdcg_pkg::CFG_W-1:0]   cfg_wdata,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_level,
    input  wire logic [bdcg_pkg::TIME_W-1:0]  s_now_ms,
    input  wire logic [bdcg_pkg::FUNC_W-1:0]  s_func,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_event_res,
    output logic                              m_short_pending,
    output logic                              m_long_pending,
    output logic                              m_triple_pending,
    output logic                              m_debounced_level
);
    import bdcg_pkg::*;

    `include "button_debounce_click_gesture_macros.svh"

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              level_reg;
    logic [TIME_W-1:0] now_reg;
    logic [FUNC_W-1:0] func_reg;
    logic              m_valid_reg;
    result_t           result_reg;
    result_t           result_next;
    logic              step_fire;
    logic              s_fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ms    <= DEBOUNCE_RST;
            cfg_reg.long_hold_ms <= LONG_HOLD_RST;
            cfg_reg.click_gap_ms <= CLICK_GAP_RST;
        end else if (cfg_wen) begin
            unique case (cfg_idx)
                CFG_DEBOUNCE:  cfg_reg.settle_ms    <= cfg_wdata;
                CFG_LONG_HOLD: cfg_reg.long_hold_ms <= cfg_wdata;
                CFG_CLICK_GAP: cfg_reg.click_gap_ms <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // Step the held item whenever the result register is free or draining
    assign step_fire = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || step_fire;
    assign s_fire    = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            level_reg <= s_level;
            now_reg   <= s_now_ms;
            func_reg  <= s_func;
        end
    end

    bdcg_gesture u_gesture (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .fire_i   (step_fire),
        .level_i  (level_reg),
        .now_i    (now_reg),
        .func_i   (func_reg),
        .cfg_i    (cfg_reg),
        .result_o (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_fire) begin
            result_reg <= result_next;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_event_res       = result_reg.event_res;
    assign m_short_pending   = result_reg.short_pending;
    assign m_long_pending    = result_reg.long_pending;
    assign m_triple_pending  = result_reg.triple_pending;
    assign m_debounced_level = result_reg.debounced_level;

    `BDCG_ASSERT(a_step_loads_result, aclk, aresetn, step_fire |=> m_valid_reg, "stepped item gave no result")
    `BDCG_ASSERT(a_hold_waiting_item, aclk, aresetn, in_valid_reg && !step_fire |=> in_valid_reg && $stable(now_reg) && $stable(func_reg), "waiting item lost or changed")
    `BDCG_ASSERT(a_accept_fills_input, aclk, aresetn, s_fire |=> in_valid_reg, "accepted item not held")

endmodule

`default_nettype wire

// ----- tb/sv/tb_button_debounce_click_gesture.sv -----
// ----------------------------------------------------------------------------
// Button debounce and click gesture: self-checking testbench
// Drives poll items with random idle gaps and receiver stalls. A cycle-free
// model of the debouncer and the click counter predicts the results that the
// table does not fix, and each result is checked field by field. A short table of
// polls opens the run. A click burst long enough to saturate the counter
// follows, then random gesture sequences under several timing settings.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_gesture;
    import bdcg_pkg::*;

    localparam int unsigned IDLE_LIMIT  = 5000;
    localparam int unsigned POLL_TARGET = 1950;
    localparam int unsigned SAT_CLICKS  = 260;
    localparam int unsigned HOLD_OFF    = 200;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic                level;
        logic [TIME_W-1:0]   now_ms;
        logic [FUNC_W-1:0]   func;
        logic                typed;
        result_t             res;
    } poll_row_t;

    // res bits: event, short, long, triple, debounced level
    localparam poll_row_t POLL_TABLE [25] = '{
        '{1'b1, 32'd0,    FUNC_NONE,   1'b1, 5'b00001},   // idle after reset
        '{1'b0, 32'd100,  FUNC_SHORT,  1'b0, 5'b00000},
        '{1'b0, 32'd131,  FUNC_NONE,   1'b1, 5'b00000},   // press accepted
        '{1'b1, 32'd200,  FUNC_LONG,   1'b0, 5'b00000},
        '{1'b1, 32'd231,  FUNC_NONE,   1'b0, 5'b00000},   // first click
        '{1'b0, 32'd300,  FUNC_TRIPLE, 1'b0, 5'b00000},
        '{1'b0, 32'd331,  FUNC_SHORT,  1'b0, 5'b00000},
        '{1'b1, 32'd400,  FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd431,  FUNC_LONG,   1'b0, 5'b00000},   // second click
        '{1'b0, 32'd500,  FUNC_NONE,   1'b0, 5'b00000},
        '{1'b0, 32'd531,  FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd600,  FUNC_SHORT,  1'b0, 5'b00000},
        '{1'b1, 32'd631,  FUNC_NONE,   1'b0, 5'b00000},   // third click
        '{1'b1, 32'd1132, FUNC_TRIPLE, 1'b1, 5'b10001},   // burst closes: triple
        '{1'b0, 32'd2000, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b0, 32'd2031, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd7031, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd7062, FUNC_LONG,   1'b1, 5'b10001},   // long press consumed
        '{1'b0, 32'd8000, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b0, 32'd8031, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd8100, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd8131, FUNC_NONE,   1'b0, 5'b00000},
        '{1'b1, 32'd8632, FUNC_LONG,   1'b0, 5'b00000},   // short left pending
        '{1'b0, 32'hFFFF_FFFF, FUNC_SHORT, 1'b0, 5'b00000},
        '{1'b0, 32'h0000_001F, FUNC_NONE,  1'b0, 5'b00000} // wraps past zero
    };

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wen = 1'b0;
    logic [IDX_W-1:0]   cfg_idx = CFG_DEBOUNCE;
    logic [CFG_W-1:0]   cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_level = 1'b1;
    logic [TIME_W-1:0]  s_now_ms = '0;
    logic [FUNC_W-1:0]  s_func = FUNC_NONE;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_event_res;
    logic               m_short_pending;
    logic               m_long_pending;
    logic               m_triple_pending;
    logic               m_debounced_level;

    // Gesture tracker state
    logic [CFG_W-1:0]   deb_ms, hold_ms, gap_ms;
    logic               raw_q, level_q;
    logic [TIME_W-1:0]  change_ms, press_ms, click_ms;
    logic [COUNT_W-1:0] clicks;
    logic               short_f, long_f, triple_f;

    result_t            gesture_reports[$];
    result_t            seen_res, want_res;
    logic [TIME_W-1:0]  clock_ms = '0;
    int unsigned        polls_sent = 0;
    int unsigned        results_seen = 0;
    int unsigned        errors = 0;
    int unsigned        settings = 1;
    int unsigned        short_hits = 0, long_hits = 0, triple_hits = 0;
    int unsigned        calm_left = 0;
    int unsigned        idle_cycles = 0;

    button_debounce_click_gesture DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wen           (cfg_wen),
        .cfg_idx           (cfg_idx),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_level           (s_level),
        .s_now_ms          (s_now_ms),
        .s_func            (s_func),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_event_res       (m_event_res),
        .m_short_pending   (m_short_pending),
        .m_long_pending    (m_long_pending),
        .m_triple_pending  (m_triple_pending),
        .m_debounced_level (m_debounced_level)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        deb_ms    = DEBOUNCE_RST;
        hold_ms   = LONG_HOLD_RST;
        gap_ms    = CLICK_GAP_RST;
        raw_q     = LEVEL_IDLE;
        level_q   = LEVEL_IDLE;
        change_ms = '0;
        press_ms  = '0;
        click_ms  = '0;
        clicks    = '0;
        short_f   = 1'b0;
        long_f    = 1'b0;
        triple_f  = 1'b0;
    end

    function automatic result_t track_button(input logic lvl, input logic [TIME_W-1:0] t,
                                             input logic [FUNC_W-1:0] f);
        result_t r;
        logic [TIME_W-1:0] stable_for, held_for, quiet_for;
        if (lvl != raw_q) begin
            change_ms = t;
            raw_q = lvl;
        end
        stable_for = t - change_ms;
        if (stable_for > TIME_W'(deb_ms) && lvl != level_q) begin
            level_q = lvl;
            held_for = t - press_ms;
            if (!level_q) begin
                press_ms = t;
            end else if (held_for >= TIME_W'(hold_ms)) begin
                long_f = 1'b1;
                clicks = '0;
            end else begin
                if (clicks != COUNT_MAX)
                    clicks = clicks + COUNT_W'(1);
                click_ms = t;
            end
        end
        quiet_for = t - click_ms;
        if (clicks != '0 && quiet_for > TIME_W'(gap_ms)) begin
            if (clicks >= TRIPLE_COUNT)
                triple_f = 1'b1;
            else
                short_f = 1'b1;
            clicks = '0;
        end
        r = '0;
        case (f)
            FUNC_SHORT: begin
                r.event_res = short_f;
                short_hits += short_f;
                short_f = 1'b0;
            end
            FUNC_LONG: begin
                r.event_res = long_f;
                long_hits += long_f;
                long_f = 1'b0;
            end
            FUNC_TRIPLE: begin
                r.event_res = triple_f;
                triple_hits += triple_f;
                triple_f = 1'b0;
            end
            default: r.event_res = 1'b0;
        endcase
        r.short_pending   = short_f;
        r.long_pending    = long_f;
        r.triple_pending  = triple_f;
        r.debounced_level = level_q;
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones, and calm stretches
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (calm_left != 0) begin
            calm_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic send_poll(input logic lvl, input logic [TIME_W-1:0] t,
                             input logic [FUNC_W-1:0] f, input logic typed,
                             input result_t typed_res);
        int unsigned gap;
        result_t r;
        gap = pick_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid  <= 1'b1;
        s_level  <= lvl;
        s_now_ms <= t;
        s_func   <= f;
        do @(posedge aclk); while (!s_ready);
        r = track_button(lvl, t, f);
        gesture_reports.push_back(typed ? typed_res : r);
        polls_sent++;
    endtask

    task automatic tick(input logic lvl, input logic [TIME_W-1:0] advance_ms);
        clock_ms = clock_ms + advance_ms;
        send_poll(lvl, clock_ms, FUNC_W'($urandom_range(0, 3)), 1'b0, '0);
    endtask

    // Move the pin to a new level and hold it until it is accepted,
    // with contact bounce and mid-window polls unless lean
    task automatic settle(input logic lvl, input logic lean);
        tick(lvl, $urandom_range(1, 3));
        if (!lean && $urandom_range(0, 3) == 0) begin
            tick(~lvl, $urandom_range(0, deb_ms));
            tick(lvl, $urandom_range(0, deb_ms));
        end
        if (!lean && $urandom_range(0, 2) == 0)
            tick(lvl, $urandom_range(0, deb_ms));
        tick(lvl, TIME_W'(deb_ms) + 1 + $urandom_range(0, 2));
    endtask

    task automatic gesture();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            repeat ($urandom_range(1, 5)) begin
                settle(1'b0, 1'b0);
                settle(1'b1, 1'b0);
            end
            if ($urandom_range(0, 3) != 0)
                tick(1'b1, TIME_W'(gap_ms) + 1 + $urandom_range(0, 3));
        end else if (roll < 80) begin
            settle(1'b0, 1'b0);
            tick(1'b0, TIME_W'(hold_ms) + $urandom_range(0, 5));
            settle(1'b1, 1'b0);
        end else begin
            // noise: random levels, jumps in either direction
            repeat ($urandom_range(1, 4))
                tick(1'($urandom_range(0, 1)),
                     ($urandom_range(0, 1) != 0) ? $urandom : $urandom_range(0, deb_ms + 2));
        end
    endtask

    // Stop offering and let every outstanding result come out
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (gesture_reports.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_timing(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] hold,
                              input logic [CFG_W-1:0] gap);
        @(negedge aclk);
        cfg_wen   <= 1'b1;
        cfg_idx   <= CFG_DEBOUNCE;
        cfg_wdata <= deb;
        @(negedge aclk);
        cfg_idx   <= CFG_LONG_HOLD;
        cfg_wdata <= hold;
        @(negedge aclk);
        cfg_idx   <= CFG_CLICK_GAP;
        cfg_wdata <= gap;
        @(negedge aclk);
        // unmapped index, must be ignored
        cfg_idx   <= CFG_UNUSED;
        cfg_wdata <= CFG_W'($urandom);
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        deb_ms  = deb;
        hold_ms = hold;
        gap_ms  = gap;
        settings++;
    endtask

    // Result side: random stalls plus one long hold-off
    initial begin
        int unsigned stall_left;
        int unsigned hold_left;
        bit          held_off;
        stall_left = 0;
        hold_left  = 0;
        held_off   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (!held_off && results_seen >= 300) begin
                held_off  = 1'b1;
                hold_left = HOLD_OFF - 1;
                m_ready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(0, 99) < 20) begin
                stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                         : $urandom_range(0, 2);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_res = {m_event_res, m_short_pending, m_long_pending,
                        m_triple_pending, m_debounced_level};
            results_seen++;
            if (gesture_reports.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result %0d arrived with nothing outstanding: %b",
                             results_seen, seen_res);
            end else begin
                want_res = gesture_reports.pop_front();
                if (seen_res.event_res       !== want_res.event_res      ||
                    seen_res.short_pending   !== want_res.short_pending  ||
                    seen_res.long_pending    !== want_res.long_pending   ||
                    seen_res.triple_pending  !== want_res.triple_pending ||
                    seen_res.debounced_level !== want_res.debounced_level) begin
                    errors++;
                    if (errors <= 10)
                        $display("result %0d: expected ev=%b sh=%b lg=%b tr=%b lvl=%b, ",
                                 results_seen, want_res.event_res, want_res.short_pending,
                                 want_res.long_pending, want_res.triple_pending,
                                 want_res.debounced_level,
                                 "got ev=%b sh=%b lg=%b tr=%b lvl=%b",
                                 seen_res.event_res,
                                 seen_res.short_pending, seen_res.long_pending,
                                 seen_res.triple_pending, seen_res.debounced_level);
                end
            end
        end
    end

    // Watchdog: cycles with no item moving on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int unsigned deb;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < 25; i++)
            send_poll(POLL_TABLE[i].level, POLL_TABLE[i].now_ms, POLL_TABLE[i].func,
                      POLL_TABLE[i].typed, POLL_TABLE[i].res);
        clock_ms = POLL_TABLE[24].now_ms;
        drain();

        // Fastest debounce, widest windows: push the click counter past its ceiling
        set_timing('0, '1, '1);
        repeat (SAT_CLICKS) begin
            settle(1'b0, 1'b1);
            settle(1'b1, 1'b1);
        end
        tick(1'b1, 32'd65536 + $urandom_range(0, 3));
        drain();

        // Slowest debounce, every release long, no click window
        set_timing('1, '0, '0);
        repeat (6) gesture();
        drain();

        while (polls_sent < POLL_TARGET) begin
            deb = $urandom_range(0, 40);
            set_timing(CFG_W'(deb), CFG_W'($urandom_range(deb + 5, 600)),
                       CFG_W'($urandom_range(1, 250)));
            clock_ms = $urandom;
            repeat ($urandom_range(4, 10)) gesture();
            drain();
        end
        repeat (8) @(posedge aclk);
        if (gesture_reports.size() != 0)
            errors++;

        $display("%0d polls over %0d timing settings, %0d results checked, %0d mismatches",
                 polls_sent, settings, results_seen, errors);
        $display("gestures consumed: %0d short, %0d long, %0d triple; click count saturated",
                 short_hits, long_hits, triple_hits);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/bdcg_pkg.sv
rtl/bdcg_gesture.sv
rtl/button_debounce_click_gesture.sv
tb/sv/tb_button_debounce_click_gesture.sv
